// File: sv/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands used by the RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// cond must hold at every rising clock edge outside reset
`define ASSERT_ALWAYS(label, clk, rst, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("assertion failed: always");

// same-cycle implication
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: implies");

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: next");

`endif

// File: sv/ids_pkg.sv
// ----------------------------------------------------------------------------
// ids_pkg
// Types and codes of the id set table.
// ----------------------------------------------------------------------------
package ids_pkg;

  localparam int ID_BITS    = 32;
  localparam int SLOT_BITS  = 4;
  localparam int TOTAL_BITS = 5;

  localparam logic [1:0] OP_ADD    = 2'd0;
  localparam logic [1:0] OP_DEL    = 2'd1;
  localparam logic [1:0] OP_SEARCH = 2'd2;
  localparam logic [1:0] OP_READ   = 2'd3;

  typedef struct packed {
    logic [1:0]           kind;
    logic [ID_BITS-1:0]   id;
    logic [SLOT_BITS-1:0] slot_index;
  } in_item_t;

  typedef struct packed {
    logic                  status;
    logic                  found;
    logic [SLOT_BITS-1:0]  found_slot;
    logic [ID_BITS-1:0]    read_id;
    logic [TOTAL_BITS-1:0] entry_total;
    logic                  is_full;
    logic                  is_empty;
  } out_item_t;

  // engine status seen by the top level
  typedef struct packed {
    logic busy;    // an item is in the engine
    logic commit;  // result handed over, write-back this cycle
  } seq_stat_t;

endpackage

// File: sv/ids_req_if.sv
// ----------------------------------------------------------------------------
// ids_req_if
// Request channel: one operation per beat.
// ----------------------------------------------------------------------------
interface ids_req_if import ids_pkg::*; ();
  logic     valid;
  logic     ready;
  in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: sv/ids_rsp_if.sv
// ----------------------------------------------------------------------------
// ids_rsp_if
// Response channel: one result per beat.
// ----------------------------------------------------------------------------
interface ids_rsp_if import ids_pkg::*; ();
  logic      valid;
  logic      ready;
  out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: sv/ids_ram.sv
// ----------------------------------------------------------------------------
// ids_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module ids_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: sv/ids_seq.sv
// ----------------------------------------------------------------------------
// ids_seq
// Operation sequencer: scans the slots one per cycle, keeps the valid
// flags and entry count, and writes back on commit.
// ----------------------------------------------------------------------------
module ids_seq import ids_pkg::*; #(
  parameter int CAPACITY = 16,
  parameter int ID_WIDTH = 32
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      acc_valid,
  output logic      acc_ready,
  input  in_item_t  acc_item,
  output logic      res_valid,
  input  logic      res_ready,
  output out_item_t res_item,
  output seq_stat_t stat
);

  localparam int SLOT_W = $clog2(CAPACITY);
  localparam int CNT_W  = $clog2(CAPACITY + 1);
  localparam logic [CNT_W-1:0]  CAP_CNT   = CNT_W'(CAPACITY);
  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(CAPACITY - 1);
  localparam logic [SLOT_W:0]   PTR_END   = (SLOT_W + 1)'(CAPACITY);
  localparam logic [ID_WIDTH-1:0] NO_ID   = {ID_WIDTH{1'b1}};

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  // control
  logic [1:0]          state;
  logic [CAPACITY-1:0] valid;
  logic [CNT_W-1:0]    count;
  logic [SLOT_W:0]     ptr;
  logic                pend;

  // payload
  logic [1:0]           kind_r;
  logic [ID_WIDTH-1:0]  key_r;
  logic                 rsv_r;
  logic [SLOT_BITS-1:0] idx_r;
  logic                 idx_ok_r;
  logic [SLOT_W-1:0]    pend_slot;
  out_item_t            res;
  logic [CNT_W-1:0]     res_cnt;
  logic                 cm_add;
  logic                 cm_del;
  logic [SLOT_W-1:0]    cm_slot;

  logic [ID_WIDTH-1:0]   key_in;
  logic [SLOT_W-1:0]     idx_addr;
  logic                  idx_ok;
  logic [SLOT_W-1:0]     ptr_lo;
  logic [ID_WIDTH-1:0]   rdata;
  logic                  hit;
  logic                  last;
  logic                  fin;
  logic                  fin_status;
  logic                  fin_found;
  logic [SLOT_W-1:0]     fin_slot;
  logic [ID_WIDTH-1:0]   fin_rid;
  logic                  fin_add;
  logic                  fin_del;
  logic                  issue;
  logic                  step;
  logic [CNT_W-1:0]      count_after;
  logic [SLOT_BITS-1:0]  fin_fs;
  logic [ID_BITS-1:0]    fin_rid32;
  logic [TOTAL_BITS-1:0] fin_tot;
  logic                  commit;

  // width adaption between the fixed port fields and the parameters
  if (ID_WIDTH > ID_BITS) begin : g_key_wide
    assign key_in    = {{(ID_WIDTH - ID_BITS){1'b0}}, acc_item.id};
    assign fin_rid32 = fin_rid[ID_BITS-1:0];
  end else if (ID_WIDTH == ID_BITS) begin : g_key_eq
    assign key_in    = acc_item.id;
    assign fin_rid32 = fin_rid;
  end else begin : g_key_narrow
    assign key_in    = acc_item.id[ID_WIDTH-1:0];
    assign fin_rid32 = {{(ID_BITS - ID_WIDTH){1'b0}}, fin_rid};
  end

  if (SLOT_W > SLOT_BITS) begin : g_slot_wide
    assign idx_addr = {{(SLOT_W - SLOT_BITS){1'b0}}, acc_item.slot_index};
    assign fin_fs   = (kind_r == OP_READ) ? idx_r : fin_slot[SLOT_BITS-1:0];
  end else if (SLOT_W == SLOT_BITS) begin : g_slot_eq
    assign idx_addr = acc_item.slot_index;
    assign fin_fs   = (kind_r == OP_READ) ? idx_r : fin_slot;
  end else begin : g_slot_narrow
    assign idx_addr = acc_item.slot_index[SLOT_W-1:0];
    assign fin_fs   = (kind_r == OP_READ) ? idx_r
                                          : {{(SLOT_BITS - SLOT_W){1'b0}}, fin_slot};
  end

  if (CNT_W >= TOTAL_BITS) begin : g_cnt_wide
    assign fin_tot = count_after[TOTAL_BITS-1:0];
  end else begin : g_cnt_narrow
    assign fin_tot = {{(TOTAL_BITS - CNT_W){1'b0}}, count_after};
  end

  assign idx_ok = (32'(acc_item.slot_index) < 32'(CAPACITY));
  assign ptr_lo = ptr[SLOT_W-1:0];

  ids_ram #(
    .WIDTH (ID_WIDTH),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk   (clk),
    .we    (commit && cm_add),
    .waddr (cm_slot),
    .wdata (key_r),
    .raddr (ptr_lo),
    .rdata (rdata)
  );

  always_comb begin
    fin        = 1'b0;
    fin_status = 1'b0;
    fin_found  = 1'b0;
    fin_slot   = '0;
    fin_rid    = '0;
    fin_add    = 1'b0;
    fin_del    = 1'b0;
    issue      = 1'b0;
    step       = 1'b0;
    // rdata belongs to pend_slot, read in the cycle before
    hit  = pend && valid[pend_slot] && (rdata == key_r);
    last = pend && (pend_slot == LAST_SLOT);
    if (state == ST_SCAN) begin
      unique case (kind_r)
        OP_ADD: begin
          priority if (rsv_r || count >= CAP_CNT || ptr == PTR_END) begin
            fin        = 1'b1;
            fin_status = 1'b1;
          end else if (!valid[ptr_lo]) begin
            fin      = 1'b1;
            fin_slot = ptr_lo;
            fin_add  = 1'b1;
          end else begin
            step = 1'b1;
          end
        end
        OP_DEL, OP_SEARCH: begin
          priority if (rsv_r) begin
            fin        = 1'b1;
            fin_status = 1'b1;
          end else if (hit) begin
            fin       = 1'b1;
            fin_slot  = pend_slot;
            fin_found = (kind_r == OP_SEARCH);
            fin_del   = (kind_r == OP_DEL);
          end else if (last) begin
            fin        = 1'b1;
            fin_status = (kind_r == OP_DEL);
          end else begin
            issue = 1'b1;
          end
        end
        OP_READ: begin
          priority if (!idx_ok_r) begin
            fin     = 1'b1;
            fin_rid = NO_ID;
          end else if (pend) begin
            fin       = 1'b1;
            fin_found = valid[pend_slot];
            fin_rid   = valid[pend_slot] ? rdata : NO_ID;
          end else begin
            issue = 1'b1;
          end
        end
      endcase
    end
    priority if (fin_add) begin
      count_after = count + CNT_W'(1);
    end else if (fin_del) begin
      count_after = count - CNT_W'(1);
    end else begin
      count_after = count;
    end
  end

  assign commit = (state == ST_DONE) && res_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      valid <= '0;
      count <= '0;
      pend  <= 1'b0;
      ptr   <= '0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (acc_valid) begin
            ptr   <= (acc_item.kind == OP_READ) ? {1'b0, idx_addr} : '0;
            pend  <= 1'b0;
            state <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          priority if (fin) begin
            pend  <= 1'b0;
            state <= ST_DONE;
          end else if (issue) begin
            pend <= 1'b1;
            ptr  <= ptr + 1'b1;
          end else if (step) begin
            ptr <= ptr + 1'b1;
          end else begin
            ptr <= ptr;
          end
        end
        ST_DONE: begin
          if (res_ready) begin
            if (cm_add) valid[cm_slot] <= 1'b1;
            if (cm_del) valid[cm_slot] <= 1'b0;
            count <= res_cnt;
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_IDLE && acc_valid) begin
      kind_r   <= acc_item.kind;
      key_r    <= key_in;
      rsv_r    <= (key_in == NO_ID);
      idx_r    <= acc_item.slot_index;
      idx_ok_r <= idx_ok;
    end
    if (issue) begin
      pend_slot <= ptr_lo;
    end
    if (fin) begin
      res.status      <= fin_status;
      res.found       <= fin_found;
      res.found_slot  <= fin_fs;
      res.read_id     <= fin_rid32;
      res.entry_total <= fin_tot;
      res.is_full     <= (count_after == CAP_CNT);
      res.is_empty    <= (count_after == '0);
      res_cnt         <= count_after;
      cm_add          <= fin_add;
      cm_del          <= fin_del;
      cm_slot         <= fin_slot;
    end
  end

  assign acc_ready   = (state == ST_IDLE);
  assign res_valid   = (state == ST_DONE);
  assign res_item    = res;
  assign stat.busy   = (state != ST_IDLE);
  assign stat.commit = commit;

endmodule

// File: sv/id_set_table.sv
// ----------------------------------------------------------------------------
// id_set_table
// Fixed-capacity set of ids: add, delete, search and read-slot operations.
// ----------------------------------------------------------------------------
// Scan: search/delete scan one slot per cycle through the id RAM's read
// port. Flow: a new item is accepted only after the last one is handed
// over; its result waits in the output register while the next item is
// scanned.
// Reset: valid flags and entry count clear; id RAM not cleared.
`include "assert_macros.svh"

module id_set_table import ids_pkg::*; #(
  parameter int CAPACITY = 16,
  parameter int ID_WIDTH = 32
) (
  input  logic      clk,
  input  logic      rst,
  ids_req_if.sink   req,
  ids_rsp_if.source rsp
);

  logic      res_valid;
  logic      res_ready;
  out_item_t res_item;
  seq_stat_t stat;
  logic      out_valid;
  out_item_t out_data;

  ids_seq #(
    .CAPACITY (CAPACITY),
    .ID_WIDTH (ID_WIDTH)
  ) u_seq (
    .clk       (clk),
    .rst       (rst),
    .acc_valid (req.valid),
    .acc_ready (req.ready),
    .acc_item  (req.data),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res_item  (res_item),
    .stat      (stat)
  );

  // output register decouples the engine from the response sink
  assign res_ready = !out_valid || rsp.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_data <= res_item;
    end
  end

  assign rsp.valid = out_valid;
  assign rsp.data  = out_data;

  `ASSERT_NEXT(a_accept_busy, clk, rst, req.valid && req.ready, stat.busy)
  `ASSERT_IMPLIES(a_busy_not_ready, clk, rst, stat.busy, !req.ready)
  `ASSERT_NEXT(a_commit_out, clk, rst, stat.commit, rsp.valid)
  `ASSERT_IMPLIES(a_err_clean, clk, rst, rsp.valid && rsp.data.status,
                  !rsp.data.found && rsp.data.found_slot == '0)

endmodule

// File: tb/sv/id_set_table_tb.sv
// ----------------------------------------------------------------------------
// id_set_table_tb
// Self-checking bench for the id set table. A short table of directed
// operations comes first: the reset state, the reserved id, a fill to full
// and an add into a full table. Random operations follow, in bursts that
// fill, drain and mix evenly in turn. Each result beat is checked field by
// field against the row's expected result or an in-bench model of the slot
// store. Random request gaps and response stalls, with quiet stretches.
// ----------------------------------------------------------------------------
module id_set_table_tb;
  import ids_pkg::*;

  localparam int SLOTS = 16;
  localparam logic [ID_BITS-1:0] NO_ID = '1;
  localparam int RAND_OPS = 1150;
  localparam int MAX_ERR_LINES = 60;

  typedef struct {
    in_item_t  op;
    bit        typed;   // expected result written in the row
    out_item_t want;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  ids_req_if req ();
  ids_rsp_if rsp ();

  id_set_table #(
    .CAPACITY(SLOTS),
    .ID_WIDTH(ID_BITS)
  ) dut (
    .clk(clk),
    .rst(rst),
    .req(req),
    .rsp(rsp)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // model of the slot store
  logic [ID_BITS-1:0] tbl_ids [SLOTS];
  bit                 tbl_used [SLOTS];
  int                 tbl_count = 0;

  out_item_t result_q [$];
  dir_row_t  dir_tab [$];
  logic [ID_BITS-1:0] id_pool [8];
  int  err_count = 0;
  bit  calm = 1'b0;

  function automatic int lookup_slot(logic [ID_BITS-1:0] key);
    for (int i = 0; i < SLOTS; i++)
      if (tbl_used[i] && tbl_ids[i] == key) return i;
    return -1;
  endfunction

  function automatic out_item_t apply_op(in_item_t op);
    out_item_t r;
    int s;
    r = '0;
    s = -1;
    case (op.kind)
      OP_ADD: begin
        if (op.id != NO_ID && tbl_count < SLOTS) begin
          for (int i = SLOTS - 1; i >= 0; i--)
            if (!tbl_used[i]) s = i;
          tbl_ids[s]  = op.id;
          tbl_used[s] = 1'b1;
          tbl_count++;
          r.found_slot = SLOT_BITS'(s);
        end else begin
          r.status = 1'b1;
        end
      end
      OP_DEL: begin
        if (op.id != NO_ID) s = lookup_slot(op.id);
        if (s < 0) begin
          r.status = 1'b1;
        end else begin
          tbl_used[s] = 1'b0;
          tbl_count--;
          r.found_slot = SLOT_BITS'(s);
        end
      end
      OP_SEARCH: begin
        if (op.id == NO_ID) begin
          r.status = 1'b1;
        end else begin
          s = lookup_slot(op.id);
          if (s >= 0) begin
            r.found      = 1'b1;
            r.found_slot = SLOT_BITS'(s);
          end
        end
      end
      default: begin
        r.found_slot = op.slot_index;
        r.read_id    = NO_ID;
        if (tbl_used[op.slot_index]) begin
          r.found   = 1'b1;
          r.read_id = tbl_ids[op.slot_index];
        end
      end
    endcase
    r.entry_total = TOTAL_BITS'(tbl_count);
    r.is_full     = (tbl_count == SLOTS);
    r.is_empty    = (tbl_count == 0);
    return r;
  endfunction

  function automatic out_item_t lit(logic st, logic fd, logic [SLOT_BITS-1:0] sl,
                                    logic [ID_BITS-1:0] rid, logic [TOTAL_BITS-1:0] tot,
                                    logic full, logic empty);
    out_item_t r;
    r = {st, fd, sl, rid, tot, full, empty};
    return r;
  endfunction

  function automatic void add_row(logic [1:0] kind, logic [ID_BITS-1:0] id,
                                  logic [SLOT_BITS-1:0] sl, bit typed, out_item_t want);
    dir_row_t row;
    row.op    = {kind, id, sl};
    row.typed = typed;
    row.want  = want;
    dir_tab.push_back(row);
  endfunction

  function automatic int pick_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [ID_BITS-1:0] pick_id();
    int r;
    int s;
    r = $urandom_range(0, 99);
    if (r < 55 && tbl_count > 0) begin
      s = $urandom_range(0, SLOTS - 1);
      while (!tbl_used[s]) s = (s + 1) % SLOTS;
      return tbl_ids[s];
    end
    if (r < 63) return NO_ID;
    if (r < 85) return id_pool[$urandom_range(0, 7)];
    return $urandom;
  endfunction

  // burst 0 fills, burst 1 drains, burst 2 is even
  function automatic logic [1:0] pick_kind(int burst);
    int r;
    r = $urandom_range(0, 99);
    case (burst)
      0:       return (r < 50) ? OP_ADD : (r < 62) ? OP_DEL : (r < 82) ? OP_SEARCH : OP_READ;
      1:       return (r < 15) ? OP_ADD : (r < 60) ? OP_DEL : (r < 80) ? OP_SEARCH : OP_READ;
      default: return (r < 30) ? OP_ADD : (r < 55) ? OP_DEL : (r < 80) ? OP_SEARCH : OP_READ;
    endcase
  endfunction

  // called at a falling edge, returns at the falling edge after the beat
  task automatic send_op(in_item_t op, bit typed, out_item_t want);
    int gap;
    out_item_t pred;
    gap = pick_gap();
    if (gap > 0) begin
      req.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    req.valid = 1'b1;
    req.data  = op;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
    pred = apply_op(op);
    result_q.push_back(typed ? want : pred);
    @(negedge clk);
  endtask

  task automatic field_err(string name, logic [ID_BITS-1:0] want, logic [ID_BITS-1:0] got);
    err_count++;
    if (err_count <= MAX_ERR_LINES)
      $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
  endtask

  // response checker
  always @(posedge clk) begin
    out_item_t want;
    out_item_t got;
    if (!rst && rsp.valid && rsp.ready) begin
      got = rsp.data;
      if (result_q.size() == 0) begin
        err_count++;
        if (err_count <= MAX_ERR_LINES)
          $display("%0t: unexpected result beat, expected none, got %h", $time, got);
      end else begin
        want = result_q.pop_front();
        if (got.status !== want.status)
          field_err("status", ID_BITS'(want.status), ID_BITS'(got.status));
        if (got.found !== want.found)
          field_err("found", ID_BITS'(want.found), ID_BITS'(got.found));
        if (got.found_slot !== want.found_slot)
          field_err("found_slot", ID_BITS'(want.found_slot), ID_BITS'(got.found_slot));
        if (got.read_id !== want.read_id) field_err("read_id", want.read_id, got.read_id);
        if (got.entry_total !== want.entry_total)
          field_err("entry_total", ID_BITS'(want.entry_total), ID_BITS'(got.entry_total));
        if (got.is_full !== want.is_full)
          field_err("is_full", ID_BITS'(want.is_full), ID_BITS'(got.is_full));
        if (got.is_empty !== want.is_empty)
          field_err("is_empty", ID_BITS'(want.is_empty), ID_BITS'(got.is_empty));
      end
    end
  end

  // response side back-pressure
  initial begin
    int stall_left;
    int r;
    stall_left = 0;
    rsp.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (calm) begin
        rsp.ready = 1'b1;
      end else if (stall_left > 0) begin
        rsp.ready = 1'b0;
        stall_left--;
      end else begin
        rsp.ready = 1'b1;
        r = $urandom_range(0, 99);
        if (r < 3) stall_left = $urandom_range(10, 40);
        else if (r < 25) stall_left = $urandom_range(1, 3);
      end
    end
  end

  initial begin
    in_item_t op;
    int burst;
    req.valid = 1'b0;
    req.data  = '0;
    for (int i = 0; i < SLOTS; i++) tbl_used[i] = 1'b0;
    id_pool[0] = '0;
    id_pool[1] = 32'hFFFF_FFFE;
    for (int i = 2; i < 8; i++) begin
      id_pool[i] = $urandom;
      if (id_pool[i] == NO_ID) id_pool[i] = 32'h0000_0001;
    end

    add_row(OP_READ,   '0,           4'd0,  1, lit(0, 0, 4'd0, NO_ID, 5'd0, 0, 1));
    add_row(OP_SEARCH, '0,           4'd0,  1, lit(0, 0, 4'd0, '0, 5'd0, 0, 1));
    add_row(OP_DEL,    32'd5,        4'd0,  1, lit(1, 0, 4'd0, '0, 5'd0, 0, 1));
    add_row(OP_ADD,    NO_ID,        4'd0,  1, lit(1, 0, 4'd0, '0, 5'd0, 0, 1));
    add_row(OP_DEL,    NO_ID,        4'd0,  1, lit(1, 0, 4'd0, '0, 5'd0, 0, 1));
    add_row(OP_SEARCH, NO_ID,        4'd0,  1, lit(1, 0, 4'd0, '0, 5'd0, 0, 1));
    add_row(OP_ADD,    '0,           4'd0,  1, lit(0, 0, 4'd0, '0, 5'd1, 0, 0));
    add_row(OP_ADD,    32'hFFFF_FFFE, 4'd0, 1, lit(0, 0, 4'd1, '0, 5'd2, 0, 0));
    add_row(OP_ADD,    '0,           4'd0,  0, '0);   // duplicate id
    add_row(OP_SEARCH, '0,           4'd0,  0, '0);
    add_row(OP_DEL,    '0,           4'd0,  0, '0);
    add_row(OP_READ,   '0,           4'd0,  0, '0);
    for (int i = 0; i < 14; i++)
      add_row(OP_ADD, i * 32'h1111_1111 + 32'd1, 4'd0, 0, '0);
    add_row(OP_ADD,    32'd7,        4'd0,  1, lit(1, 0, 4'd0, '0, 5'd16, 1, 0));
    add_row(OP_READ,   '0,           4'd15, 0, '0);
    add_row(OP_SEARCH, 32'hFFFF_FFFE, 4'd0, 0, '0);

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (dir_tab[i]) send_op(dir_tab[i].op, dir_tab[i].typed, dir_tab[i].want);

    for (int n = 0; n < RAND_OPS; n++) begin
      calm  = ((n % 150) >= 115);
      burst = (n / 50) % 3;
      op.kind       = pick_kind(burst);
      op.id         = pick_id();
      op.slot_index = SLOT_BITS'($urandom_range(0, SLOTS - 1));
      send_op(op, 0, '0);
    end
    req.valid = 1'b0;
    calm = 1'b0;

    while (result_q.size() != 0) @(posedge clk);
    repeat (2 * SLOTS + 8) @(posedge clk);
    if (err_count == 0 && result_q.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #(8_000_000);
    $display("Some tests failed");
    $finish;
  end

endmodule

// File: files.f
+incdir+sv
sv/ids_pkg.sv
sv/ids_req_if.sv
sv/ids_rsp_if.sv
sv/ids_ram.sv
sv/ids_seq.sv
sv/id_set_table.sv
tb/sv/id_set_table_tb.sv
